// ===== sv/lidar_scan_packet_parser_unit_macros.svh =====
// Assertion macros shared by the lidar scan packet parser RTL.
// Included by the files that assert; no other dependencies.
`ifndef LIDAR_SCAN_PACKET_PARSER_UNIT_MACROS_SVH
`define LIDAR_SCAN_PACKET_PARSER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only while the block is out of reset.
`define LSPP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("lspp assertion failed");
// Checked at every edge, reset included.
`define LSPP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("lspp assertion failed");
`else
`define LSPP_ASSERT(lbl, clk, rst_n, prop)
`define LSPP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/lspp_pkg.sv =====
// Package for the lidar scan packet parser: packet layout constants,
// configuration register indexes and shared types. No dependencies.
`default_nettype none

package lspp_pkg;

  localparam int PKT_BYTES = 5;
  localparam int WIN_DEPTH = PKT_BYTES - 1;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int WIN_IDX_W = $clog2(WIN_DEPTH);

  localparam int ANGLE_W   = 15;
  localparam int DIST_W    = 16;
  localparam int QUAL_W    = 6;
  localparam int MAXPTS_W  = 10;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_POINTS = 2'd1;

  localparam logic [DIST_W-1:0]   MIN_DIST_RESET   = 16'd400;
  localparam logic [MAXPTS_W-1:0] MAX_POINTS_RESET = 10'd460;

  // Bit positions inside the first two packet bytes.
  localparam int SYNC_POS   = 0;
  localparam int SYNC_N_POS = 1;
  localparam int CHK_POS    = 0;

  typedef logic [PKT_BYTES-1:0][7:0] pkt_bytes_t;

  typedef struct packed {
    logic                ok;
    logic                start;
    logic [ANGLE_W-1:0]  angle;
    logic [DIST_W-1:0]   echo_dist;
    logic [QUAL_W-1:0]   quality;
  } pkt_info_t;

  typedef struct packed {
    logic [ANGLE_W-1:0]  angle_q6;
    logic [DIST_W-1:0]   dist_q2;
    logic [QUAL_W-1:0]   quality;
    logic                no_return;
    logic                first_point;
  } point_t;

endpackage

`default_nettype wire

// ===== sv/lspp_decode.sv =====
// Field decoder for one five-byte packet window: framing check and raw
// angle, distance and quality extraction. Depends on lspp_pkg.
`default_nettype none

module lspp_decode
  import lspp_pkg::*;
(
  input  pkt_bytes_t pkt_i,
  output pkt_info_t  info_o
);

  always_comb begin
    // The start bit and its inverse must disagree, and the check bit must be set.
    info_o.ok        = (pkt_i[0][SYNC_POS] != pkt_i[0][SYNC_N_POS]) &&
                       pkt_i[1][CHK_POS];
    info_o.start     = pkt_i[0][SYNC_POS];
    info_o.angle     = {pkt_i[2], pkt_i[1][7:1]};
    info_o.echo_dist = {pkt_i[4], pkt_i[3]};
    info_o.quality   = pkt_i[0][7:2];
  end

endmodule

`default_nettype wire

// ===== sv/lidar_scan_packet_parser_unit.sv =====
// Top level of the lidar scan packet parser: byte window, scan tracking,
// output register with skid slot. Depends on lspp_pkg, lspp_decode, macros header.
// One received byte is taken per cycle while the input is not stalled. The
// point from the byte that completes a packet is registered into the output
// register; a second register behind it holds one more point so input
// keeps flowing while the output stalls, and the input stalls only while both
// slots are full. The only loop is the update of the byte window and the scan
// counter, which sets the rate at one byte per cycle while not stalled.
`default_nettype none
`include "lidar_scan_packet_parser_unit_macros.svh"

module lidar_scan_packet_parser_unit
  import lspp_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ANGLE_W-1:0]        angle_q6_o,
  output logic [DIST_W-1:0]         dist_q2_o,
  output logic [QUAL_W-1:0]         quality_o,
  output logic                      no_return_o,
  output logic                      first_point_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DAT_W-1:0] cfg_wdata_i
);

  logic [DIST_W-1:0]   min_dist_q;
  logic [MAXPTS_W-1:0] max_points_q;

  logic [WIN_DEPTH-1:0][7:0] win_q, win_d;
  logic [FILL_W-1:0]         fill_q, fill_d;
  logic                      collecting_q, collecting_d;
  logic [MAXPTS_W-1:0]       points_q, points_d;

  logic   out_valid_q, skid_valid_q;
  point_t out_q, skid_q;

  logic      in_fire, out_fire, cfg_fire;
  logic      res_valid;
  point_t    res;
  pkt_info_t info;
  logic      [MAXPTS_W-1:0] pts_base;
  logic      coll_next;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_fire    = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q   <= MIN_DIST_RESET;
      max_points_q <= MAX_POINTS_RESET;
    end else if (cfg_fire) begin
      unique case (cfg_index_i)
        CFG_MIN_DIST:   min_dist_q   <= cfg_wdata_i;
        CFG_MAX_POINTS: max_points_q <= cfg_wdata_i[MAXPTS_W-1:0];
        default: ;
      endcase
    end
  end

  lspp_decode u_decode (
    .pkt_i  ({rx_byte_i, win_q}),
    .info_o (info)
  );

  always_comb begin
    win_d        = win_q;
    fill_d       = fill_q;
    collecting_d = collecting_q;
    points_d     = points_q;
    res_valid    = 1'b0;
    coll_next    = collecting_q || info.start;
    pts_base     = info.start ? '0 : points_q;

    res.angle_q6    = info.angle;
    res.no_return   = (info.quality == '0);
    res.dist_q2     = res.no_return ? '0 : info.echo_dist;
    res.quality     = info.quality;
    res.first_point = (pts_base == '0);

    priority if (fill_q < FILL_W'(WIN_DEPTH)) begin
      win_d[fill_q[WIN_IDX_W-1:0]] = rx_byte_i;
      fill_d = fill_q + 1'b1;
    end else if (!info.ok) begin
      // Bad framing: slide the window forward by one byte.
      win_d = {rx_byte_i, win_q[WIN_DEPTH-1:1]};
    end else begin
      fill_d       = '0;
      collecting_d = coll_next;
      points_d     = pts_base;
      // Near echoes are dropped and do not count toward the cap.
      if (coll_next && (pts_base < max_points_q) &&
          (res.no_return || (info.echo_dist >= min_dist_q))) begin
        res_valid = 1'b1;
        points_d  = pts_base + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q        <= '0;
      fill_q       <= '0;
      collecting_q <= 1'b0;
      points_q     <= '0;
    end else if (in_fire) begin
      win_q        <= win_d;
      fill_q       <= fill_d;
      collecting_q <= collecting_d;
      points_q     <= points_d;
    end
  end

  // Output register plus one skid slot; the skid drains first to keep order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire && res_valid) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign angle_q6_o    = out_q.angle_q6;
  assign dist_q2_o     = out_q.dist_q2;
  assign quality_o     = out_q.quality;
  assign no_return_o   = out_q.no_return;
  assign first_point_o = out_q.first_point;

  `LSPP_ASSERT_ALWAYS(a_skid_behind_out, clk_i, skid_valid_q |-> out_valid_q)
  `LSPP_ASSERT(a_fill_bounded, clk_i, rst_ni, fill_q <= FILL_W'(WIN_DEPTH))
  `LSPP_ASSERT(a_idle_no_points, clk_i, rst_ni, !collecting_q |-> (points_q == '0))
  `LSPP_ASSERT(a_result_lands, clk_i, rst_ni, (in_fire && res_valid) |=> out_valid_q)
  `LSPP_ASSERT(a_point_counted, clk_i, rst_ni, (in_fire && res_valid) |=> (points_q != '0))

endmodule

`default_nettype wire

// ===== test/lidar_scan_packet_parser_unit_test.sv =====
// Self-checking testbench for lidar_scan_packet_parser_unit: byte stream in, decoded points out.
// Depends on lspp_pkg and the parser RTL; predicts every point and checks it at the output.
`timescale 1ns / 1ps

module lidar_scan_packet_parser_unit_test;
  import lspp_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int CFG_SETTLE     = 4;
  localparam int END_SETTLE     = 8;
  localparam int LONG_HOLD      = 300;
  localparam int MAX_REPORTS    = 10;

  // Indexes that decode to no register.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [7:0]           rx_byte_i = 8'h00;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [ANGLE_W-1:0]   angle_q6_o;
  logic [DIST_W-1:0]    dist_q2_o;
  logic [QUAL_W-1:0]    quality_o;
  logic                 no_return_o;
  logic                 first_point_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata_i = '0;

  lidar_scan_packet_parser_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .rx_byte_i     (rx_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .angle_q6_o    (angle_q6_o),
    .dist_q2_o     (dist_q2_o),
    .quality_o     (quality_o),
    .no_return_o   (no_return_o),
    .first_point_o (first_point_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shadow copy of the parser state and its registers.
  logic [7:0]          win_q [WIN_DEPTH];
  int                  win_fill = 0;
  bit                  scan_open = 1'b0;
  logic [MAXPTS_W-1:0] pts_sent = '0;
  logic [DIST_W-1:0]   min_dist_cfg = MIN_DIST_RESET;
  logic [MAXPTS_W-1:0] max_pts_cfg = MAX_POINTS_RESET;

  point_t pending_points[$];
  int     mismatch_cnt = 0;
  int     bytes_sent = 0;
  bit     tx_idle_on = 1'b1;
  bit     rx_idle_on = 1'b1;
  int     hold_req = 0;

  // Returns 1 when the byte completes a packet that goes out as a point.
  function automatic bit predict_point(input logic [7:0] b, output point_t pt);
    logic [7:0]        p0, p1, p2, p3;
    logic [DIST_W-1:0] echo_dist;
    logic [QUAL_W-1:0] q;
    pt = '0;
    if (win_fill < WIN_DEPTH) begin
      win_q[win_fill] = b;
      win_fill++;
      return 1'b0;
    end
    p0 = win_q[0];
    p1 = win_q[1];
    p2 = win_q[2];
    p3 = win_q[3];
    if (p0[SYNC_POS] == p0[SYNC_N_POS] || !p1[CHK_POS]) begin
      win_q[0] = p1;
      win_q[1] = p2;
      win_q[2] = p3;
      win_q[3] = b;
      return 1'b0;
    end
    win_fill = 0;
    if (p0[SYNC_POS]) begin
      scan_open = 1'b1;
      pts_sent  = '0;
    end
    if (!scan_open || pts_sent >= max_pts_cfg) return 1'b0;
    echo_dist = {b, p3};
    q         = p0[7:2];
    if (q != '0 && echo_dist < min_dist_cfg) return 1'b0;
    pt.angle_q6    = {p2, p1[7:1]};
    pt.dist_q2     = (q == '0) ? '0 : echo_dist;
    pt.quality     = q;
    pt.no_return   = (q == '0);
    pt.first_point = (pts_sent == '0);
    pts_sent++;
    return 1'b1;
  endfunction

  task automatic push_rx_byte(input logic [7:0] b);
    int     gap;
    point_t pt;
    gap = tx_idle_on ? $urandom_range(0, 19) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_point(b, pt)) pending_points.push_back(pt);
    bytes_sent++;
  endtask

  task automatic push_packet(input bit start, input bit inv, input bit chk,
                             input logic [5:0] q, input logic [14:0] ang,
                             input logic [15:0] echo_dist);
    push_rx_byte({q, inv, start});
    push_rx_byte({ang[6:0], chk});
    push_rx_byte(ang[14:7]);
    push_rx_byte(echo_dist[7:0]);
    push_rx_byte(echo_dist[15:8]);
  endtask

  task automatic push_beam(input bit start, input logic [5:0] q, input logic [14:0] ang,
                           input logic [15:0] echo_dist);
    push_packet(start, !start, 1'b1, q, ang, echo_dist);
  endtask

  // Drops the input valid left high by the last transfer, then waits for all points.
  task automatic wait_points_drained();
    if (in_valid_i) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DAT_W-1:0] data);
    wait_points_drained();
    repeat (CFG_SETTLE) @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MIN_DIST) min_dist_cfg = data;
    else if (idx == CFG_MAX_POINTS) max_pts_cfg = data[MAXPTS_W-1:0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed packets, some broken ones and loose noise bytes.
  task automatic run_random_bytes(input int n);
    int         stop;
    int         r;
    int         d;
    bit         st;
    logic [5:0] q;
    stop = bytes_sent + n;
    while (bytes_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        st = ($urandom_range(0, 7) == 0);
        q  = ($urandom_range(0, 6) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
        if ($urandom_range(0, 1) == 1) begin
          d = int'(min_dist_cfg) + int'($urandom_range(0, 6)) - 3;
          if (d < 0) d = 0;
          if (d > 65535) d = 65535;
        end else begin
          d = $urandom_range(0, 65535);
        end
        push_beam(st, q, 15'($urandom), 16'(d));
      end else if (r < 90) begin
        st = $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 1) begin
          push_packet(st, st, 1'b1, 6'($urandom), 15'($urandom), 16'($urandom));
        end else begin
          push_packet(st, !st, 1'b0, 6'($urandom), 15'($urandom), 16'($urandom));
        end
      end else begin
        repeat ($urandom_range(1, 3)) push_rx_byte(8'($urandom));
      end
    end
  endtask

  task automatic test_reset_defaults();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    // No scan open yet, so this packet is dropped.
    push_beam(1'b0, 6'd5, 15'd100, 16'd1000);
    // Broken packets: start equal to its inverse, then a cleared check bit.
    push_packet(1'b1, 1'b1, 1'b1, 6'd0, 15'd0, 16'd0);
    push_packet(1'b1, 1'b0, 1'b0, 6'd0, 15'd0, 16'd0);
    push_beam(1'b1, 6'h3F, 15'h7FFF, 16'hFFFF);
    // No-return beam carries a distance that must read back as zero.
    push_beam(1'b0, 6'd0, 15'h2AAA, 16'h1234);
    push_beam(1'b0, 6'h2A, 15'h5555, MIN_DIST_RESET - 16'd1);
    push_beam(1'b0, 6'h15, 15'd1, MIN_DIST_RESET);
    push_beam(1'b1, 6'd0, 15'd0, 16'd0);
  endtask

  task automatic test_register_writes();
    write_register(CFG_SPARE_A, 16'h0000);
    write_register(CFG_SPARE_B, 16'hFFFF);
    // The minimum distance must still be the reset value.
    push_beam(1'b1, 6'd9, 15'd7, MIN_DIST_RESET - 16'd1);
    write_register(CFG_MAX_POINTS, {6'h3F, 10'd0});
    push_beam(1'b1, 6'd0, 15'd1, 16'd5);
    push_beam(1'b0, 6'd1, 15'd2, 16'hFFFF);
    write_register(CFG_MAX_POINTS, {6'h2A, 10'd1});
    push_beam(1'b1, 6'd0, 15'd3, 16'd0);
    push_beam(1'b0, 6'd0, 15'd4, 16'd0);
    push_beam(1'b1, 6'd7, 15'd5, 16'hFFFF);
  endtask

  task automatic test_random_settings();
    logic [DIST_W-1:0]   md;
    logic [MAXPTS_W-1:0] mp;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          md = 16'd0;
          mp = 10'd1023;
        end
        1: begin
          md = 16'hFFFF;
          mp = 10'd1023;
        end
        2: begin
          md = 16'($urandom);
          mp = 10'd1;
        end
        3: begin
          md = 16'($urandom_range(0, 2000));
          mp = 10'd3;
        end
        4: begin
          md = MIN_DIST_RESET;
          mp = MAX_POINTS_RESET;
        end
        default: begin
          md = 16'($urandom);
          mp = 10'($urandom_range(1, 1023));
        end
      endcase
      write_register(CFG_MIN_DIST, md);
      write_register(CFG_MAX_POINTS, {6'($urandom), mp});
      tx_idle_on = (ph % 3 != 0);
      rx_idle_on = (ph % 3 == 2);
      run_random_bytes(210);
    end
  endtask

  // The receiver holds off long enough for both output slots to fill and stall the input.
  task automatic test_output_backpressure();
    write_register(CFG_MIN_DIST, 16'd0);
    write_register(CFG_MAX_POINTS, {6'd0, 10'd1023});
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    hold_req   = LONG_HOLD;
    for (int i = 0; i < 40; i++) begin
      push_beam(i == 0, (i % 2 == 0) ? 6'd0 : 6'($urandom_range(1, 63)),
                15'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_sender_pause();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_random_bytes(80);
    wait_points_drained();
    run_random_bytes(80);
  endtask

  // Receiver: one stall length per point, or the long hold when one is requested.
  initial begin
    int w;
    forever begin
      @(negedge clk_i);
      if (hold_req > 0) begin
        w = hold_req;
        hold_req = 0;
      end else begin
        w = rx_idle_on ? $urandom_range(0, 19) : 0;
      end
      if (w > 0) begin
        out_stall_i <= 1'b1;
        repeat (w) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  point_t got_pt;
  point_t want_pt;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_pt.angle_q6    = angle_q6_o;
      got_pt.dist_q2     = dist_q2_o;
      got_pt.quality     = quality_o;
      got_pt.no_return   = no_return_o;
      got_pt.first_point = first_point_o;
      if (pending_points.size() == 0) begin
        if (mismatch_cnt < MAX_REPORTS) begin
          $display("unexpected point: angle=%0d dist=%0d q=%0d nr=%0b first=%0b",
                   got_pt.angle_q6, got_pt.dist_q2, got_pt.quality,
                   got_pt.no_return, got_pt.first_point);
        end
        mismatch_cnt++;
      end else begin
        want_pt = pending_points.pop_front();
        if (got_pt.angle_q6 !== want_pt.angle_q6 || got_pt.dist_q2 !== want_pt.dist_q2 ||
            got_pt.quality !== want_pt.quality || got_pt.no_return !== want_pt.no_return ||
            got_pt.first_point !== want_pt.first_point) begin
          if (mismatch_cnt < MAX_REPORTS) begin
            $display("point mismatch: expected angle=%0d dist=%0d q=%0d nr=%0b first=%0b",
                     want_pt.angle_q6, want_pt.dist_q2, want_pt.quality,
                     want_pt.no_return, want_pt.first_point);
            $display("                actual   angle=%0d dist=%0d q=%0d nr=%0b first=%0b",
                     got_pt.angle_q6, got_pt.dist_q2, got_pt.quality,
                     got_pt.no_return, got_pt.first_point);
          end
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog: any transfer on any channel restarts the count.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_register_writes();
    test_random_settings();
    test_output_backpressure();
    test_sender_pause();
    wait_points_drained();
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
